// ===== rtl/core/eka_pkg.sv =====
// Shared types and constants for the elliptic K AGM unit.
package eka_pkg;

  localparam int FRAC_W     = 46;
  localparam int A_W        = 48;
  localparam int HALF_W     = 24;
  localparam int RAD_W      = 96;
  localparam int REM_W      = 50;
  localparam int ROOT_STEPS = 48;
  localparam int IN_W       = 33;
  localparam int KV_W       = 32;
  localparam int STEPS_W    = 10;
  localparam int TOL_W      = 20;
  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CNT_W      = 7;
  localparam int DIV_STEPS  = 78;
  localparam int FAST_N_W   = 3;

  localparam logic [A_W-1:0]       A_ONE   = A_W'(1) << FRAC_W;
  localparam logic [IN_W-1:0]      IN_ONE  = IN_W'(1) << 32;
  localparam logic [63:0]          PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [DIV_STEPS-1:0] DIV_NUM = {PI_Q60, 14'b0};

  localparam logic [IN_W-1:0] THR_0094 = 33'd40372693;
  localparam logic [IN_W-1:0] THR_326  = 33'd1400159339;
  localparam logic [IN_W-1:0] THR_931  = 33'd3998614553;
  localparam logic [IN_W-1:0] THR_999  = 33'd4290672329;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 2'd2;

  localparam logic MODE_CONV = 1'b0;
  localparam logic MODE_FAST = 1'b1;

  typedef struct packed {
    logic       load;
    logic       sqrt_load;
    logic       sqrt_step;
    logic       g_init;
    logic       mul_step;
    logic [1:0] mul_idx;
    logic       commit;
    logic       div_load;
    logic       div_step;
  } dp_cmd_t;

  typedef struct packed {
    logic                singular;
    logic                k_zero;
    logic                diff_ok;
    logic [FAST_N_W-1:0] fast_n;
  } dp_stat_t;

endpackage

// ===== rtl/core/elliptic_k_agm_unit.sv =====
// Top level of the complete elliptic integral K(k2) unit by arithmetic-geometric mean.
// Usage:
//   Input channel in_valid/in_ready carries one beat, in_k_squared (Q1.32, 0..1).
//   Output channel out_valid/out_ready returns one beat per input: out_k_value
//   (Q4.28), out_steps_used, out_singular, out_limit_reached.
//   cfg_we/cfg_index/cfg_wdata write mode, iteration limit and tolerance; write
//   only while the unit is idle.
// Timing:
//   One beat at a time. An input with k2 of one or more skips the AGM steps and the
//   divide. The initial root is followed by the AGM steps; each step is four 24x24
//   partial products, a bit-pair square root, commit and check; then the divide.
//   The next input is taken once the result sits in the output register.
// Reset:
//   rst_n low clears the controller and output valid, and sets mode 0,
//   iteration limit 1000 and tolerance 70.
// Stall:
//   A held result waits in the output register; the unit finishes its current
//   beat and then waits before loading the next result.
module elliptic_k_agm_unit import eka_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IN_W-1:0]      in_k_squared,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KV_W-1:0]      out_k_value,
  output logic [STEPS_W-1:0]   out_steps_used,
  output logic                 out_singular,
  output logic                 out_limit_reached,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic               mode_r;
  logic [STEPS_W-1:0] limit_r;
  logic [TOL_W-1:0]   tol_r;

  logic               out_valid_r, out_valid_nxt;
  logic [KV_W-1:0]    k_value_r;
  logic [STEPS_W-1:0] steps_r;
  logic               singular_r, limit_hit_r;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [KV_W-1:0]    k_value;
  logic               out_load;
  logic [STEPS_W-1:0] steps_used;
  logic               limit_reached;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_CONV;
      limit_r <= STEPS_W'(1000);
      tol_r   <= TOL_W'(70);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_wdata[0];
        CFG_LIMIT: limit_r <= cfg_wdata[STEPS_W-1:0];
        CFG_TOL:   tol_r   <= cfg_wdata[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  eka_dp u_dp (
    .clk          (clk),
    .in_k_squared (in_k_squared),
    .cmd          (cmd),
    .tol          (tol_r),
    .k_value      (k_value),
    .stat         (stat)
  );

  eka_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode_r),
    .limit         (limit_r),
    .stat          (stat),
    .out_valid     (out_valid_r),
    .out_ready     (out_ready),
    .cmd           (cmd),
    .out_load      (out_load),
    .steps_used    (steps_used),
    .limit_reached (limit_reached)
  );

  assign out_valid_nxt = out_load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      k_value_r   <= k_value;
      steps_r     <= steps_used;
      singular_r  <= stat.singular;
      limit_hit_r <= limit_reached;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_k_value       = k_value_r;
  assign out_steps_used    = steps_r;
  assign out_singular      = singular_r;
  assign out_limit_reached = limit_hit_r;

`ifndef ASSERT_OFF
  a_singular_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && singular_r) |-> (k_value_r == '1 && steps_r == '0 && !limit_hit_r))
    else $error("singular result malformed");
  a_fast_no_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && mode_r == MODE_FAST) |=> !limit_hit_r)
    else $error("limit flag in fast mode");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(k_value_r)))
    else $error("stalled result changed");
`endif

endmodule

// ===== rtl/core/eka_dp.sv =====
// Datapath: AGM registers, partial-product multiplier, bit-pair square root, divider.
module eka_dp import eka_pkg::*; (
  input  logic             clk,
  input  logic [IN_W-1:0]  in_k_squared,
  input  dp_cmd_t          cmd,
  input  logic [TOL_W-1:0] tol,
  output logic [KV_W-1:0]  k_value,
  output dp_stat_t         stat
);

  logic [IN_W-1:0]      k_r;
  logic [A_W-1:0]       a_r, g_r;
  logic [RAD_W-1:0]     acc_r, rad_r;
  logic [REM_W-1:0]     rem_r;
  logic [A_W-1:0]       root_r;
  logic [DIV_STEPS-1:0] dnum_r;
  logic [REM_W-1:0]     drem_r;
  logic [KV_W-1:0]      q_r;
  logic                 qovf_r;

  logic [IN_W-1:0]    gap;
  logic [RAD_W-1:0]   rad0;
  logic [REM_W+1:0]   rem_sh, trial, sq_diff;
  logic               sq_ge;
  logic [HALF_W-1:0]  mop_a, mop_g;
  logic [A_W-1:0]     pp;
  logic [RAD_W-1:0]   pp_ext;
  logic [A_W:0]       sum;
  logic [A_W-1:0]     dif;
  logic [REM_W-1:0]   dsh, dext, dsub;
  logic               dge;

  assign gap  = IN_ONE - in_k_squared;
  assign rad0 = {3'b0, gap, 60'b0};

  assign rem_sh  = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial   = {2'b0, root_r, 2'b01};
  assign sq_ge   = rem_sh >= trial;
  assign sq_diff = rem_sh - trial;

  always_comb begin
    case (cmd.mul_idx)
      2'd0: begin
        mop_a  = a_r[HALF_W-1:0];
        mop_g  = g_r[HALF_W-1:0];
      end
      2'd1: begin
        mop_a  = a_r[HALF_W-1:0];
        mop_g  = g_r[A_W-1:HALF_W];
      end
      2'd2: begin
        mop_a  = a_r[A_W-1:HALF_W];
        mop_g  = g_r[HALF_W-1:0];
      end
      default: begin
        mop_a  = a_r[A_W-1:HALF_W];
        mop_g  = g_r[A_W-1:HALF_W];
      end
    endcase
  end

  assign pp = A_W'(mop_a) * A_W'(mop_g);

  always_comb begin
    case (cmd.mul_idx)
      2'd0:    pp_ext = RAD_W'(pp);
      2'd3:    pp_ext = RAD_W'(pp) << (2 * HALF_W);
      default: pp_ext = RAD_W'(pp) << HALF_W;
    endcase
  end

  assign sum = {1'b0, a_r} + {1'b0, g_r};
  assign dif = (a_r >= g_r) ? (a_r - g_r) : (g_r - a_r);

  assign dsh  = {drem_r[REM_W-2:0], dnum_r[DIV_STEPS-1]};
  assign dext = {1'b0, a_r, 1'b0};
  assign dge  = dsh >= dext;
  assign dsub = dsh - dext;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k_r    <= in_k_squared;
      a_r    <= A_ONE;
      rad_r  <= rad0;
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_load) begin
      rad_r  <= acc_r;
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b0};
      rem_r  <= sq_ge ? sq_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_r <= {root_r[A_W-2:0], sq_ge};
    end
    if (cmd.g_init) begin
      g_r <= root_r;
    end
    if (cmd.mul_step) begin
      acc_r <= (cmd.mul_idx == 2'd0) ? pp_ext : acc_r + pp_ext;
    end
    if (cmd.commit) begin
      a_r <= sum[A_W:1];
      g_r <= root_r;
    end
    if (cmd.div_load) begin
      dnum_r <= DIV_NUM;
      drem_r <= '0;
      q_r    <= '0;
      qovf_r <= 1'b0;
    end
    if (cmd.div_step) begin
      dnum_r <= {dnum_r[DIV_STEPS-2:0], 1'b0};
      drem_r <= dge ? dsub : dsh;
      q_r    <= {q_r[KV_W-2:0], dge};
      qovf_r <= qovf_r | q_r[KV_W-1];
    end
  end

  always_comb begin
    if (k_r < THR_0094)     stat.fast_n = 3'd2;
    else if (k_r < THR_326) stat.fast_n = 3'd3;
    else if (k_r < THR_931) stat.fast_n = 3'd4;
    else if (k_r < THR_999) stat.fast_n = 3'd5;
    else                    stat.fast_n = 3'd6;
  end

  assign stat.singular = k_r[IN_W-1];
  assign stat.k_zero   = (k_r == '0);
  assign stat.diff_ok  = (dif <= A_W'(tol));

  assign k_value = (stat.singular || qovf_r) ? '1 : q_r;

endmodule

// ===== rtl/core/eka_ctrl.sv =====
// Controller: sequences the initial root, AGM steps, final divide and result handoff.
module eka_ctrl import eka_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [STEPS_W-1:0] limit,
  input  dp_stat_t           stat,
  input  logic               out_valid,
  input  logic               out_ready,
  output dp_cmd_t            cmd,
  output logic               out_load,
  output logic [STEPS_W-1:0] steps_used,
  output logic               limit_reached
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ROOT0  = 9'b000000010,
    S_DECIDE = 9'b000000100,
    S_MUL    = 9'b000001000,
    S_ROOT   = 9'b000010000,
    S_COMMIT = 9'b000100000,
    S_CHECK  = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [STEPS_W-1:0]  steps_r, steps_nxt;
  logic                lim_r, lim_nxt;
  logic [FAST_N_W-1:0] n_r, n_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    steps_nxt = steps_r;
    lim_nxt   = lim_r;
    n_nxt     = n_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          steps_nxt = '0;
          lim_nxt   = 1'b0;
          state_nxt = S_ROOT0;
        end
      end
      S_ROOT0: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.g_init = 1'b1;
        cnt_nxt    = '0;
        n_nxt      = stat.fast_n;
        if (stat.singular) state_nxt = S_DONE;
        else if (mode == MODE_FAST) state_nxt = S_MUL;
        else if (stat.k_zero) state_nxt = S_DIV;
        else if (limit == '0) begin
          lim_nxt   = 1'b1;
          state_nxt = S_DIV;
        end else state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.mul_idx  = cnt_r[1:0];
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(3)) begin
          cnt_nxt   = '0;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (cnt_r == '0) cmd.sqrt_load = 1'b1;
        else cmd.sqrt_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS)) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        steps_nxt  = steps_r + 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        cnt_nxt = '0;
        if (mode == MODE_FAST) begin
          state_nxt = (steps_r == STEPS_W'(n_r)) ? S_DIV : S_MUL;
        end else if (stat.diff_ok) state_nxt = S_DIV;
        else if (steps_r == limit) begin
          lim_nxt   = 1'b1;
          state_nxt = S_DIV;
        end else state_nxt = S_MUL;
      end
      S_DIV: begin
        if (cnt_r == '0) cmd.div_load = 1'b1;
        else cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      steps_r <= '0;
      lim_r   <= 1'b0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      steps_r <= steps_nxt;
      lim_r   <= lim_nxt;
      n_r     <= n_nxt;
    end
  end

  assign steps_used    = steps_r;
  assign limit_reached = lim_r;

`ifndef ASSERT_OFF
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.sqrt_load, cmd.sqrt_step, cmd.mul_step, cmd.div_load, cmd.div_step}))
    else $error("datapath units driven together");
  a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMMIT |=> steps_r != '0)
    else $error("step count not advanced");
  a_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && mode == MODE_CONV) |-> steps_r <= limit)
    else $error("steps exceed iteration limit");
`endif

endmodule

// ===== bench/tb.sv =====
// Testbench for elliptic_k_agm_unit: directed table plus random k2 beats, checked by a predictor.
`timescale 1ns / 1ps

module tb;
  import eka_pkg::*;

  typedef struct {
    logic [KV_W-1:0]    k_value;
    logic [STEPS_W-1:0] steps;
    logic               singular;
    logic               limit_hit;
  } k_result_t;

  typedef struct {
    logic [IN_W-1:0] k2;
    logic            known;
    k_result_t       res;
  } k_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [IN_W-1:0] in_k_squared;
  logic [KV_W-1:0] out_k_value;
  logic [STEPS_W-1:0] out_steps_used;
  logic out_singular, out_limit_reached;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  logic mode_r;
  logic [STEPS_W-1:0] limit_r;
  logic [TOL_W-1:0] tol_r;
  logic stall_on;
  int errors;
  k_result_t pending_k[$];
  k_row_t directed[$];

  elliptic_k_agm_unit i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] isqrt(input logic [127:0] n);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic k_result_t predict_k(input logic [IN_W-1:0] k);
    k_result_t r;
    logic [127:0] a, g, na, q;
    logic [STEPS_W:0] n;
    logic done;
    r = '{default: '0};
    if (k >= IN_ONE) begin
      r.k_value = '1;
      r.singular = 1'b1;
      return r;
    end
    a = 128'd1 << FRAC_W;
    g = isqrt(128'(IN_ONE - k) << (2 * FRAC_W - 32));
    n = 0;
    if (mode_r == MODE_CONV) begin
      done = 1'b0;
      if (k != 0) begin
        while (n < limit_r && !done) begin
          na = (a + g) >> 1;
          g = isqrt(a * g);
          a = na;
          n++;
          if (((a >= g) ? a - g : g - a) <= tol_r) done = 1'b1;
        end
        r.limit_hit = !done;
      end
    end else begin
      if (k < THR_0094) n = 2;
      else if (k < THR_326) n = 3;
      else if (k < THR_931) n = 4;
      else if (k < THR_999) n = 5;
      else n = 6;
      for (int i = 0; i < n; i++) begin
        na = (a + g) >> 1;
        g = isqrt(a * g);
        a = na;
      end
    end
    r.steps = n[STEPS_W-1:0];
    q = (128'(PI_Q60) << (FRAC_W - 32)) / (a << 1);
    r.k_value = (q > 128'hFFFFFFFF) ? '1 : q[KV_W-1:0];
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pick_k2();
    case ($urandom_range(0, 9))
      0: return THR_0094 - 1 + $urandom_range(0, 2);
      1: return THR_326 - 1 + $urandom_range(0, 2);
      2: return THR_931 - 1 + $urandom_range(0, 2);
      3: return THR_999 - 1 + $urandom_range(0, 2);
      4: return IN_ONE - 1 - $urandom_range(0, 1000);
      5: return $urandom_range(0, 1000);
      6: return {1'b1, 32'($urandom)};
      default: return {1'b0, 32'($urandom)};
    endcase
  endfunction

  always @(posedge clk) begin
    k_result_t e;
    if (rst_n) begin
      if (in_valid && in_ready) pending_k.push_back(predict_k(in_k_squared));
      if (out_valid && out_ready) begin
        if (pending_k.size() == 0) begin
          $error("unexpected beat k_value=%h", out_k_value);
          errors++;
        end else begin
          e = pending_k.pop_front();
          if (out_k_value !== e.k_value) begin
            $error("k_value exp %h got %h", e.k_value, out_k_value); errors++;
          end
          if (out_steps_used !== e.steps) begin
            $error("steps_used exp %0d got %0d", e.steps, out_steps_used); errors++;
          end
          if (out_singular !== e.singular) begin
            $error("singular exp %b got %b", e.singular, out_singular); errors++;
          end
          if (out_limit_reached !== e.limit_hit) begin
            $error("limit_reached exp %b got %b", e.limit_hit, out_limit_reached); errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    out_ready <= 1'b1;
  end

  task automatic send_k2(input logic [IN_W-1:0] k, input logic gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_k_squared <= k;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_k.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_cfg(input logic m, input logic [STEPS_W-1:0] lim,
                           input logic [TOL_W-1:0] tol);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_MODE;  cfg_wdata <= CFG_W'(m);   @(negedge clk);
    cfg_index <= CFG_LIMIT; cfg_wdata <= CFG_W'(lim); @(negedge clk);
    cfg_index <= CFG_TOL;   cfg_wdata <= CFG_W'(tol); @(negedge clk);
    cfg_we <= 1'b0;
    mode_r = m; limit_r = lim; tol_r = tol;
  endtask

  initial begin
    logic [IN_W-1:0] k;
    errors = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_k_squared = '0; out_ready = 1'b0;
    cfg_we = 1'b0; cfg_index = CFG_MODE; cfg_wdata = '0; stall_on = 1'b1;
    mode_r = MODE_CONV; limit_r = 1000; tol_r = 70;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    directed = '{
      '{33'd0, 1'b1, '{32'h1921FB54, 10'd0, 1'b0, 1'b0}},
      '{IN_ONE, 1'b1, '{32'hFFFFFFFF, 10'd0, 1'b1, 1'b0}},
      '{33'h1FFFFFFFF, 1'b1, '{32'hFFFFFFFF, 10'd0, 1'b1, 1'b0}},
      '{33'd1, 1'b0, '{default: '0}},
      '{IN_ONE - 1, 1'b0, '{default: '0}},
      '{THR_0094, 1'b0, '{default: '0}},
      '{THR_326 - 1, 1'b0, '{default: '0}},
      '{THR_931, 1'b0, '{default: '0}},
      '{THR_999 - 1, 1'b0, '{default: '0}},
      '{33'h080000000, 1'b0, '{default: '0}},
      '{33'h0AAAAAAAA, 1'b0, '{default: '0}},
      '{33'h155555555, 1'b0, '{default: '0}}
    };
    foreach (directed[i]) begin
      send_k2(directed[i].k2, 1'b0);
      if (directed[i].known && predict_k(directed[i].k2) != directed[i].res) begin
        $error("table row %0d disagrees with predictor", i);
        errors++;
      end
    end

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: write_cfg(MODE_FAST, 10'd1000, 20'd70);
        1: write_cfg(MODE_CONV, 10'd1, 20'd0);
        2: write_cfg(MODE_CONV, 10'd1023, 20'd0);
        3: write_cfg(MODE_CONV, 10'd2, 20'hFFFFF);
        4: write_cfg(MODE_CONV, 10'd0, 20'd70);
        5: write_cfg(MODE_FAST, 10'd1023, 20'd0);
        6: write_cfg(MODE_CONV, 10'd4, 20'd1000);
        7: write_cfg(MODE_CONV, 10'd1000, 20'd70);
        default: begin
          write_cfg(MODE_CONV, 10'd1000, 20'd70);
          stall_on = 1'b0;
        end
      endcase
      for (int n = 0; n < 45; n++) begin
        if (ph == 3 && n == 20) drain_results();
        k = (ph == 8 && n < 4) ? (IN_ONE - 33'(n)) : pick_k2();
        send_k2(k, ph != 8);
      end
    end

    drain_results();
    if (errors == 0) $display("elliptic_k_agm_unit: match");
    else $display("elliptic_k_agm_unit: mismatch");
    $finish;
  end

  initial begin
    #1s;
    $display("elliptic_k_agm_unit: mismatch");
    $finish;
  end

endmodule
